/* hw/rtl/assert_macros.svh */
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/shcob_pkg.sv */
package shcob_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned CNT_W      = 27;
    localparam int unsigned PROD_W     = 2 * CNT_W;
    localparam int unsigned OUT_DATA_W = ((7 * CNT_W + 7) / 8) * 8;
    localparam int unsigned PAD_W      = OUT_DATA_W - 7 * CNT_W;

    localparam int unsigned MAX_PIXELS_DEF = 32'd67108864;

    localparam logic [BYTE_W-1:0] THR_RESET = 8'd128;

    localparam logic [BYTE_W-1:0] MAGIC [4] = '{8'h54, 8'h45, 8'h43, 8'h53};

    localparam logic [1:0] MAGIC_LAST     = 2'd3;
    localparam logic [3:0] HDR_WIDTH_END  = 4'd3;
    localparam logic [3:0] HDR_HEIGHT_END = 4'd7;
    localparam logic [3:0] HDR_FRAMES_END = 4'd11;
    localparam logic [1:0] PIX_ALPHA      = 2'd3;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_MAGIC = 2'd1,
        STAT_BAD_SIZE  = 2'd2,
        STAT_TRUNC     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_MAGIC,
        ST_HEADER,
        ST_SIZE_MUL,
        ST_SIZE_CHK,
        ST_PIXELS,
        ST_SKIP
    } t_state;

    typedef struct packed {
        logic    clear;
        logic    magic_step;
        logic    hdr_step;
        logic    size_mul;
        logic    size_load;
        logic    pix_step;
        logic    emit;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        logic magic_match;
        logic magic_last;
        logic hdr_frames_byte;
        logic pix_last_byte;
        logic pix_done;
        logic size_bad;
        logic out_free;
    } t_dp_stat;

endpackage

/* hw/rtl/shcob_dp.sv */
module shcob_dp #(
    parameter int unsigned MAX_PIXELS = shcob_pkg::MAX_PIXELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [shcob_pkg::BYTE_W-1:0]        i_cfg_wr_data,
    input  logic [shcob_pkg::BYTE_W-1:0]        i_byte,
    input  shcob_pkg::t_dp_cmd                  i_cmd,
    output shcob_pkg::t_dp_stat                 o_stat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [shcob_pkg::OUT_DATA_W-1:0]    o_out_data,
    output logic [1:0]                          o_out_status
);

    localparam int unsigned CW = shcob_pkg::CNT_W;
    localparam int unsigned PW = shcob_pkg::PROD_W;
    localparam int unsigned WW = shcob_pkg::WORD_W;

    logic [shcob_pkg::BYTE_W-1:0] r_thr;
    logic [3:0]    r_idx, n_idx;
    logic [WW-1:0] r_word, n_word;
    logic [WW-1:0] r_width, n_width;
    logic [WW-1:0] r_height, n_height;
    logic [WW-1:0] r_frames, n_frames;
    logic [1:0]    r_pix_idx, n_pix_idx;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic [CW-1:0] r_left, n_left;
    logic [CW-1:0] r_min_c, n_min_c, px_min_c;
    logic [CW-1:0] r_min_r, n_min_r, px_min_r;
    logic [CW-1:0] r_end_c, n_end_c, px_end_c;
    logic [CW-1:0] r_end_r, n_end_r, px_end_r;
    logic          r_seen, n_seen, px_seen;
    logic [PW-1:0] r_wh;
    logic [PW-1:0] r_total;
    logic          r_size_bad;
    logic          r_out_valid;
    logic [shcob_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [1:0]    r_out_status;

    logic [WW-1:0] shifted;
    logic          pix_take;
    logic          hit;
    logic [CW-1:0] col_inc;
    logic [CW-1:0] row_inc;

    assign shifted  = {i_byte, r_word[WW-1:8]};
    assign pix_take = i_cmd.pix_step && (r_pix_idx == shcob_pkg::PIX_ALPHA);
    assign hit      = pix_take && (i_byte >= r_thr);
    assign col_inc  = r_col + CW'(1);
    assign row_inc  = r_row + CW'(1);

    // box after the current pixel
    always_comb begin
        px_min_c = r_min_c;
        px_min_r = r_min_r;
        px_end_c = r_end_c;
        px_end_r = r_end_r;
        px_seen  = r_seen;
        if (hit) begin
            px_seen = 1'b1;
            if (!r_seen) begin
                px_min_c = r_col;
                px_min_r = r_row;
                px_end_c = col_inc;
                px_end_r = row_inc;
            end else begin
                if (r_col < r_min_c) px_min_c = r_col;
                if (r_row < r_min_r) px_min_r = r_row;
                if (r_col >= r_end_c) px_end_c = col_inc;
                if (r_row >= r_end_r) px_end_r = row_inc;
            end
        end
    end

    always_comb begin
        n_idx     = r_idx;
        n_word    = r_word;
        n_width   = r_width;
        n_height  = r_height;
        n_frames  = r_frames;
        n_pix_idx = r_pix_idx;
        n_col     = r_col;
        n_row     = r_row;
        n_left    = r_left;
        n_min_c   = px_min_c;
        n_min_r   = px_min_r;
        n_end_c   = px_end_c;
        n_end_r   = px_end_r;
        n_seen    = px_seen;
        if (i_cmd.clear) begin
            n_idx     = '0;
            n_word    = '0;
            n_width   = '0;
            n_height  = '0;
            n_frames  = '0;
            n_pix_idx = '0;
            n_col     = '0;
            n_row     = '0;
            n_left    = '0;
            n_min_c   = '0;
            n_min_r   = '0;
            n_end_c   = '0;
            n_end_r   = '0;
            n_seen    = 1'b0;
        end else begin
            if (i_cmd.magic_step) begin
                n_idx = (r_idx[1:0] == shcob_pkg::MAGIC_LAST) ? '0 : r_idx + 4'd1;
            end
            if (i_cmd.hdr_step) begin
                n_word = shifted;
                n_idx  = r_idx + 4'd1;
                if (r_idx == shcob_pkg::HDR_WIDTH_END) n_width = shifted;
                if (r_idx == shcob_pkg::HDR_HEIGHT_END) n_height = shifted;
                if (r_idx == shcob_pkg::HDR_FRAMES_END) n_frames = shifted;
            end
            if (i_cmd.size_load) begin
                n_left    = r_total[CW-1:0];
                n_pix_idx = '0;
                n_col     = '0;
                n_row     = '0;
            end
            if (i_cmd.pix_step) begin
                n_pix_idx = r_pix_idx + 2'd1;
                if (pix_take) begin
                    if ({5'd0, col_inc} >= r_width) begin
                        n_col = '0;
                        n_row = ({5'd0, row_inc} >= r_height) ? '0 : row_inc;
                    end else begin
                        n_col = col_inc;
                    end
                    if (r_left != '0) n_left = r_left - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= shcob_pkg::THR_RESET;
            r_idx     <= '0;
            r_word    <= '0;
            r_width   <= '0;
            r_height  <= '0;
            r_frames  <= '0;
            r_pix_idx <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_left    <= '0;
            r_min_c   <= '0;
            r_min_r   <= '0;
            r_end_c   <= '0;
            r_end_r   <= '0;
            r_seen    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_thr <= i_cfg_wr_data;
            r_idx     <= n_idx;
            r_word    <= n_word;
            r_width   <= n_width;
            r_height  <= n_height;
            r_frames  <= n_frames;
            r_pix_idx <= n_pix_idx;
            r_col     <= n_col;
            r_row     <= n_row;
            r_left    <= n_left;
            r_min_c   <= n_min_c;
            r_min_r   <= n_min_r;
            r_end_c   <= n_end_c;
            r_end_r   <= n_end_r;
            r_seen    <= n_seen;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // size check: w*h runs freely, then *frames in its own cycle
    always_ff @(posedge i_clk) begin
        r_wh <= r_width[CW-1:0] * r_height[CW-1:0];
        if (i_cmd.size_mul) begin
            r_total    <= r_wh[CW-1:0] * r_frames[CW-1:0];
            r_size_bad <= (r_width == '0) || (r_height == '0) || (r_frames == '0)
                       || (r_width > WW'(MAX_PIXELS)) || (r_height > WW'(MAX_PIXELS))
                       || (r_frames > WW'(MAX_PIXELS)) || (r_wh > PW'(MAX_PIXELS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.code;
            if (i_cmd.code == shcob_pkg::STAT_OK) begin
                if (px_seen) begin
                    r_out_data <= {{shcob_pkg::PAD_W{1'b0}}, px_end_r, px_end_c, px_min_r,
                                   px_min_c, r_frames[CW-1:0], r_height[CW-1:0],
                                   r_width[CW-1:0]};
                end else begin
                    r_out_data <= {{shcob_pkg::PAD_W{1'b0}}, r_height[CW-1:0],
                                   r_width[CW-1:0], {CW{1'b0}}, {CW{1'b0}},
                                   r_frames[CW-1:0], r_height[CW-1:0], r_width[CW-1:0]};
                end
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign o_stat.magic_match     = (i_byte == shcob_pkg::MAGIC[r_idx[1:0]]);
    assign o_stat.magic_last      = (r_idx[1:0] == shcob_pkg::MAGIC_LAST);
    assign o_stat.hdr_frames_byte = (r_idx == shcob_pkg::HDR_FRAMES_END);
    assign o_stat.pix_last_byte   = (r_pix_idx == shcob_pkg::PIX_ALPHA);
    assign o_stat.pix_done        = (r_left == CW'(1));
    assign o_stat.size_bad        = r_size_bad || (r_total > PW'(MAX_PIXELS));
    assign o_stat.out_free        = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_out_status = r_out_status;

endmodule

/* hw/rtl/shcob_ctrl.sv */
`include "assert_macros.svh"

module shcob_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_last,
    output logic                  o_in_ready,
    input  shcob_pkg::t_dp_stat   i_stat,
    output shcob_pkg::t_dp_cmd    o_cmd
);

    shcob_pkg::t_state r_state, n_state;
    logic              r_eof_pend, n_eof_pend;
    logic              take;
    logic              in_size_chk;
    logic              in_size;
    logic              eof_now;

    assign in_size_chk = (r_state == shcob_pkg::ST_SIZE_CHK);
    assign in_size     = (r_state == shcob_pkg::ST_SIZE_MUL) || in_size_chk;
    assign o_in_ready  = i_stat.out_free && !in_size;
    assign take        = i_in_valid && o_in_ready;
    assign eof_now     = (take && i_in_last) || (in_size_chk && r_eof_pend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= shcob_pkg::ST_MAGIC;
            r_eof_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_eof_pend <= n_eof_pend;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_eof_pend = r_eof_pend;
        o_cmd      = '0;
        o_cmd.code = shcob_pkg::STAT_OK;
        unique case (r_state)
            shcob_pkg::ST_MAGIC: begin
                if (take) begin
                    if (!i_stat.magic_match) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.code = shcob_pkg::STAT_BAD_MAGIC;
                        n_state    = shcob_pkg::ST_SKIP;
                    end else begin
                        o_cmd.magic_step = 1'b1;
                        if (i_stat.magic_last) n_state = shcob_pkg::ST_HEADER;
                    end
                    if (i_in_last) begin
                        if (i_stat.magic_match) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.code = shcob_pkg::STAT_TRUNC;
                        end
                        o_cmd.clear = 1'b1;
                        n_state     = shcob_pkg::ST_MAGIC;
                    end
                end
            end
            shcob_pkg::ST_HEADER: begin
                if (take) begin
                    o_cmd.hdr_step = 1'b1;
                    if (i_stat.hdr_frames_byte) begin
                        n_eof_pend = i_in_last;
                        n_state    = shcob_pkg::ST_SIZE_MUL;
                    end else if (i_in_last) begin
                        o_cmd.emit  = 1'b1;
                        o_cmd.code  = shcob_pkg::STAT_TRUNC;
                        o_cmd.clear = 1'b1;
                        n_state     = shcob_pkg::ST_MAGIC;
                    end
                end
            end
            shcob_pkg::ST_SIZE_MUL: begin
                o_cmd.size_mul = 1'b1;
                n_state        = shcob_pkg::ST_SIZE_CHK;
            end
            shcob_pkg::ST_SIZE_CHK: begin
                if (i_stat.out_free) begin
                    if (i_stat.size_bad) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.code = shcob_pkg::STAT_BAD_SIZE;
                        n_state    = shcob_pkg::ST_SKIP;
                    end else if (r_eof_pend) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.code = shcob_pkg::STAT_TRUNC;
                    end else begin
                        o_cmd.size_load = 1'b1;
                        n_state         = shcob_pkg::ST_PIXELS;
                    end
                    if (r_eof_pend) begin
                        o_cmd.clear = 1'b1;
                        n_state     = shcob_pkg::ST_MAGIC;
                    end
                    n_eof_pend = 1'b0;
                end
            end
            shcob_pkg::ST_PIXELS: begin
                if (take) begin
                    o_cmd.pix_step = 1'b1;
                    if (i_stat.pix_last_byte && i_stat.pix_done) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.code = shcob_pkg::STAT_OK;
                        n_state    = shcob_pkg::ST_SKIP;
                    end else if (i_in_last) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.code = shcob_pkg::STAT_TRUNC;
                    end
                    if (i_in_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = shcob_pkg::ST_MAGIC;
                    end
                end
            end
            shcob_pkg::ST_SKIP: begin
                if (take && i_in_last) begin
                    o_cmd.clear = 1'b1;
                    n_state     = shcob_pkg::ST_MAGIC;
                end
            end
            default: begin
                n_state = shcob_pkg::ST_MAGIC;
            end
        endcase
    end

    `ASSERT_IMPLY(a_no_take_in_size, i_clk, i_rst_n, in_size, !o_in_ready)
    `ASSERT_IMPLY(a_emit_needs_slot, i_clk, i_rst_n, o_cmd.emit, i_stat.out_free)
    `ASSERT_NEXT(a_mul_then_chk, i_clk, i_rst_n, r_state == shcob_pkg::ST_SIZE_MUL, in_size_chk)
    `ASSERT_IMPLY(a_clear_cause, i_clk, i_rst_n, o_cmd.clear, eof_now)

endmodule

/* hw/rtl/sprite_header_check_and_opaque_box_unit.sv */
// channel    | dir | tdata                               | tuser      | tlast
// -----------+-----+-------------------------------------+------------+------------
// s_axis     | in  | file_byte                           | -          | end_of_file
// m_axis     | out | width..box_bottom, 27b each         | status     | -
// cfg        | in  | i_cfg_wr_data = alpha_threshold     | -          | -
//
// one byte per cycle through magic, header and pixels while s_axis_tready is high
// after the frames byte s_axis_tready is low in ST_SIZE_MUL (w*h*frames multiply) and ST_SIZE_CHK (compare),
// and stays low while the output register still holds a word that m_axis does not take
// one output register; otherwise s_axis stalls only while it holds an untaken word
// synchronous active-low reset: state cleared, alpha_threshold back to 128
module sprite_header_check_and_opaque_box_unit #(
    parameter int unsigned MAX_PIXELS = shcob_pkg::MAX_PIXELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [shcob_pkg::BYTE_W-1:0]        i_cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [shcob_pkg::BYTE_W-1:0]        s_axis_tdata,   // file_byte
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // image_width, image_height, frame_count, box_left, box_top, box_right, box_bottom, pad
    output logic [shcob_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic [1:0]                          m_axis_tuser    // status
);

    shcob_pkg::t_dp_cmd  cmd;
    shcob_pkg::t_dp_stat stat;

    shcob_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    shcob_dp #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte        (s_axis_tdata),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata),
        .o_out_status  (m_axis_tuser)
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned CNT_W = shcob_pkg::CNT_W;
    localparam int unsigned BYTE_W = shcob_pkg::BYTE_W;

    typedef enum logic [1:0] {
        PH_MAGIC,
        PH_HEADER,
        PH_PIXELS,
        PH_SKIP
    } t_parse_phase;

    typedef struct {
        shcob_pkg::t_status status;
        logic [6:0][CNT_W-1:0] dim;
    } t_box_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [BYTE_W-1:0] i_cfg_wr_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata = '0;   // file_byte
    logic s_axis_tlast = 1'b0;              // end_of_file
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // image_width, image_height, frame_count, box_left, box_top, box_right, box_bottom, pad
    logic [shcob_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;               // status

    sprite_header_check_and_opaque_box_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // parser copy
    t_parse_phase ph;
    logic [3:0] hdr_idx;
    logic [31:0] shift_word, width_w, height_w, frames_w;
    logic [1:0] pix_idx;
    logic [CNT_W-1:0] col, row, pix_left, min_col, min_row, end_col, end_row;
    logic opaque_seen;
    logic [BYTE_W-1:0] thr_model;

    t_box_result pending_boxes[$];
    logic [7:0] file_q[$];
    int unsigned send_idle = 8;
    int unsigned recv_idle = 83;
    bit hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;

    string dim_name [7] = '{"image_width", "image_height", "frame_count", "box_left",
                            "box_top", "box_right", "box_bottom"};

    // {end_of_file, file_byte}
    logic [8:0] dir_rows [23] = '{
        9'h058, 9'h145, 9'h154,
        9'h054, 9'h045, 9'h043, 9'h053,
        9'h001, 9'h000, 9'h000, 9'h000,
        9'h001, 9'h000, 9'h000, 9'h000,
        9'h001, 9'h000, 9'h000, 9'h000,
        9'h000, 9'h000, 9'h000, 9'h1FF
    };

    function automatic void clear_file_state();
        ph = PH_MAGIC;
        hdr_idx = '0;
        shift_word = '0;
        width_w = '0;
        height_w = '0;
        frames_w = '0;
        pix_idx = '0;
        col = '0;
        row = '0;
        pix_left = '0;
        min_col = '0;
        min_row = '0;
        end_col = '0;
        end_row = '0;
        opaque_seen = 1'b0;
    endfunction

    function automatic bit predict_sprite_byte(input logic [7:0] b, input logic eof,
                                               output t_box_result res);
        logic [63:0] wh;
        bit got;
        bit size_good;
        got = 1'b0;
        res = '{shcob_pkg::STAT_OK, '0};
        case (ph)
            PH_MAGIC: begin
                if (b != shcob_pkg::MAGIC[hdr_idx[1:0]]) begin
                    res.status = shcob_pkg::STAT_BAD_MAGIC;
                    got = 1'b1;
                    ph = PH_SKIP;
                end else begin
                    hdr_idx = hdr_idx + 1'b1;
                    if (hdr_idx >= 4'd4) begin
                        hdr_idx = '0;
                        ph = PH_HEADER;
                    end
                end
            end
            PH_HEADER: begin
                shift_word = (shift_word >> 8) | {b, 24'd0};
                hdr_idx = hdr_idx + 1'b1;
                if (hdr_idx == 4'd4) begin
                    width_w = shift_word;
                end else if (hdr_idx == 4'd8) begin
                    height_w = shift_word;
                end else if (hdr_idx >= 4'd12) begin
                    frames_w = shift_word;
                    size_good = width_w != 0 && height_w != 0 && frames_w != 0 &&
                                !(width_w[31] || height_w[31] || frames_w[31]);
                    wh = {32'd0, width_w} * {32'd0, height_w};
                    size_good = size_good && wh <= 64'(shcob_pkg::MAX_PIXELS_DEF) &&
                                wh * {32'd0, frames_w} <= 64'(shcob_pkg::MAX_PIXELS_DEF);
                    if (!size_good) begin
                        res.status = shcob_pkg::STAT_BAD_SIZE;
                        got = 1'b1;
                        ph = PH_SKIP;
                    end else begin
                        pix_left = CNT_W'(width_w * height_w * frames_w);
                        pix_idx = '0;
                        col = '0;
                        row = '0;
                        ph = PH_PIXELS;
                    end
                end
            end
            PH_PIXELS: begin
                if (pix_idx == 2'd3) begin
                    if (b >= thr_model) begin
                        if (!opaque_seen) begin
                            min_col = col;
                            min_row = row;
                            end_col = col + 1'b1;
                            end_row = row + 1'b1;
                            opaque_seen = 1'b1;
                        end else begin
                            if (col < min_col) min_col = col;
                            if (row < min_row) min_row = row;
                            if (col >= end_col) end_col = col + 1'b1;
                            if (row >= end_row) end_row = row + 1'b1;
                        end
                    end
                    col = col + 1'b1;
                    if (col >= width_w) begin
                        col = '0;
                        row = row + 1'b1;
                        if (row >= height_w) row = '0;
                    end
                    if (pix_left > 0) pix_left = pix_left - 1'b1;
                    if (pix_left == 0) begin
                        res.status = shcob_pkg::STAT_OK;
                        res.dim[0] = width_w[CNT_W-1:0];
                        res.dim[1] = height_w[CNT_W-1:0];
                        res.dim[2] = frames_w[CNT_W-1:0];
                        if (opaque_seen) begin
                            res.dim[3] = min_col;
                            res.dim[4] = min_row;
                            res.dim[5] = end_col;
                            res.dim[6] = end_row;
                        end else begin
                            res.dim[5] = width_w[CNT_W-1:0];
                            res.dim[6] = height_w[CNT_W-1:0];
                        end
                        got = 1'b1;
                        ph = PH_SKIP;
                    end
                end
                pix_idx = pix_idx + 1'b1;
            end
            default: ;
        endcase
        if (eof) begin
            if (!got && ph != PH_SKIP) begin
                res = '{shcob_pkg::STAT_TRUNC, '0};
                got = 1'b1;
            end
            clear_file_state();
        end
        return got;
    endfunction

    task automatic feed_byte(input logic [7:0] b, input logic eof,
                             output bit got, output t_box_result res);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= eof;
        do @(posedge i_clk); while (!s_axis_tready);
        got = predict_sprite_byte(b, eof, res);
    endtask

    task automatic set_alpha_threshold(input logic [7:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        thr_model = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++) file_q.push_back(w[8*k +: 8]);
    endtask

    task automatic put_magic();
        for (int k = 0; k < 4; k++) file_q.push_back(shcob_pkg::MAGIC[k]);
    endtask

    task automatic build_random_file();
        int kind;
        int dens;
        int cut;
        int k;
        logic [31:0] w, h, f;
        logic [7:0] wrong;
        logic [7:0] thr;
        file_q.delete();
        thr = thr_model;
        kind = $urandom_range(99);
        if (kind < 55 || kind >= 90) begin
            case ($urandom_range(2))
                0: begin
                    w = $urandom_range(6, 1);
                    h = $urandom_range(4, 1);
                    f = $urandom_range(3, 1);
                end
                1: begin
                    w = $urandom_range(32, 1);
                    h = $urandom_range(2, 1);
                    f = 1;
                end
                default: begin
                    w = $urandom_range(2, 1);
                    h = $urandom_range(32, 1);
                    f = 1;
                end
            endcase
            if (w * h * f > 32) f = 1;
            put_magic();
            put_word(w);
            put_word(h);
            put_word(f);
            if (kind >= 90) begin
                // cut inside magic or header
                cut = $urandom_range(14, 0);
                while (file_q.size() > cut + 1) void'(file_q.pop_back());
            end else begin
                case ($urandom_range(3))
                    0: dens = 0;
                    1: dens = 10;
                    2: dens = 35;
                    default: dens = 100;
                endcase
                repeat (w * h * f) begin
                    repeat (3) file_q.push_back($urandom_range(255));
                    if ($urandom_range(99) < dens || thr == 0)
                        file_q.push_back($urandom_range(255, thr));
                    else
                        file_q.push_back($urandom_range(thr - 1, 0));
                end
                case ($urandom_range(3))
                    0: repeat ($urandom_range(5, 1)) file_q.push_back($urandom_range(255));
                    1: begin
                        cut = $urandom_range(file_q.size() - 2, 16);
                        while (file_q.size() > cut + 1) void'(file_q.pop_back());
                    end
                    default: ;
                endcase
            end
        end else if (kind < 70) begin
            put_magic();
            case ($urandom_range(7))
                0: begin w = 0; h = $urandom_range(4, 1); f = 1; end
                1: begin w = $urandom_range(4, 1); h = 0; f = $urandom_range(4, 1); end
                2: begin w = 1; h = 1; f = 0; end
                3: begin w = $urandom; h = $urandom; f = $urandom; end
                4: begin
                    w = $urandom_range(4, 1) | 32'h8000_0000;
                    h = 1;
                    f = $urandom | 32'h8000_0000;
                end
                5: begin w = 32'h0400_0001; h = 1; f = 1; end
                6: begin w = 32'h0000_2000; h = 32'h0000_2000; f = 2; end
                default: begin w = 32'h7FFF_FFFF; h = w; f = w; end
            endcase
            put_word(w);
            put_word(h);
            put_word(f);
            repeat ($urandom_range(3, 0)) file_q.push_back($urandom_range(255));
        end else if (kind < 78) begin
            // accepted sizes at or just below the limit, file ends early
            case ($urandom_range(5))
                0: begin w = 32'h0400_0000; h = 1; f = 1; end
                1: begin w = 1; h = 32'h0400_0000; f = 1; end
                2: begin w = 1; h = 1; f = 32'h0400_0000; end
                3: begin w = 32'h2000; h = 32'h2000; f = 1; end
                4: begin w = 32'h400; h = 32'h400; f = 32'h40; end
                default: begin w = 32'h03FF_FFFF; h = 1; f = 1; end
            endcase
            put_magic();
            put_word(w);
            put_word(h);
            put_word(f);
            repeat ($urandom_range(12, 0)) file_q.push_back($urandom_range(255));
        end else begin
            k = $urandom_range(3, 0);
            for (int j = 0; j < k; j++) file_q.push_back(shcob_pkg::MAGIC[j]);
            do wrong = $urandom_range(255); while (wrong == shcob_pkg::MAGIC[k]);
            file_q.push_back(wrong);
            repeat ($urandom_range(4, 0)) file_q.push_back($urandom_range(255));
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_box_result want;
        logic [6:0][CNT_W-1:0] got_dim;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_boxes.size() == 0) begin
                errors++;
                $display("%0t unexpected word: expected none, actual status %0d",
                         $time, m_axis_tuser);
            end else begin
                want = pending_boxes.pop_front();
                got_dim = m_axis_tdata[7*CNT_W-1:0];
                if (m_axis_tuser !== want.status) begin
                    errors++;
                    $display("%0t status: expected %0d, actual %0d",
                             $time, want.status, m_axis_tuser);
                end
                for (int k = 0; k < 7; k++) begin
                    if (got_dim[k] !== want.dim[k]) begin
                        errors++;
                        $display("%0t %s: expected %0d, actual %0d",
                                 $time, dim_name[k], want.dim[k], got_dim[k]);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        bit got;
        t_box_result res;
        int seg_bytes;
        int seg_files;
        logic [7:0] next_thr;
        clear_file_state();
        thr_model = shcob_pkg::THR_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 23; i++) begin
            feed_byte(dir_rows[i][7:0], dir_rows[i][8], got, res);
            if (got) begin
                case (i)
                    0: res = '{shcob_pkg::STAT_BAD_MAGIC, '0};
                    2: res = '{shcob_pkg::STAT_TRUNC, '0};
                    22: res = '{shcob_pkg::STAT_OK,
                                {27'd1, 27'd1, 27'd0, 27'd0, 27'd1, 27'd1, 27'd1}};
                    default: ;
                endcase
                pending_boxes.push_back(res);
            end
        end

        for (int seg = 0; seg < 3; seg++) begin
            if (seg == 0) begin
                send_idle = 8;
                recv_idle = 83;
                next_thr = 8'd0;
            end else if (seg == 1) begin
                send_idle = 83;
                recv_idle = 8;
                next_thr = 8'd255;
            end else begin
                send_idle = 0;
                recv_idle = 0;
                next_thr = $urandom_range(254, 1);
            end
            set_alpha_threshold(next_thr);
            if (seg == 2) hold_request = 1'b1;
            seg_bytes = 0;
            seg_files = 0;
            while (seg_bytes < 540 || seg_files < 16) begin
                build_random_file();
                for (int k = 0; k < file_q.size(); k++) begin
                    feed_byte(file_q[k], k == file_q.size() - 1, got, res);
                    if (got) pending_boxes.push_back(res);
                end
                seg_bytes += file_q.size();
                seg_files++;
                if (seg_files % 6 == 0) begin
                    case ($urandom_range(3))
                        0: next_thr = 8'd0;
                        1: next_thr = 8'd255;
                        2: next_thr = 8'd1;
                        default: next_thr = $urandom_range(255);
                    endcase
                    set_alpha_threshold(next_thr);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
